FILE: hw/rtl/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg - shared definitions for the cartridge bank controller
// Register indexes, access codes, RAM sizing and the bank mapping helpers.
// ----------------------------------------------------------------------------
package cbc_pkg;

    // Cartridge RAM size in bytes: a power of two from 2048 to 32768.
    localparam int CART_RAM_BYTES = 32768;
    localparam int RAM_AW         = $clog2(CART_RAM_BYTES);

    // Configuration register indexes
    localparam logic CFG_ROM_SIZE = 1'b0;
    localparam logic CFG_RAM_SIZE = 1'b1;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // RAM size codes
    localparam logic [2:0] RAM_2K  = 3'd1;
    localparam logic [2:0] RAM_8K  = 3'd2;
    localparam logic [2:0] RAM_32K = 3'd3;

    // ROM size codes with special handling
    localparam logic [2:0] ROM_32K = 3'd0;
    localparam logic [2:0] ROM_1M  = 3'd5;
    localparam logic [2:0] ROM_2M  = 3'd6;

    localparam logic [3:0] RAM_EN_KEY  = 4'hA;
    localparam logic [7:0] OPEN_BUS    = 8'hFF;

    // Clamp code 7 onto the 2MB code
    function automatic logic [2:0] eff_rom_code(input logic [2:0] code);
        return (code > ROM_2M) ? ROM_2M : code;
    endfunction

    // ROM bank mask per size code
    function automatic logic [4:0] bank_mask(input logic [2:0] code);
        logic [4:0] m;
        case (code)
            3'd0:    m = 5'h01;
            3'd1:    m = 5'h03;
            3'd2:    m = 5'h07;
            3'd3:    m = 5'h0F;
            default: m = 5'h1F;
        endcase
        return m;
    endfunction

    // Upper bank bits (bank bits 6:5) taken from the RAM bank register
    function automatic logic [1:0] upper_bits(input logic [2:0] code,
                                              input logic [1:0] ram_bank);
        logic [1:0] u;
        if (code == ROM_1M) begin
            u = {1'b0, ram_bank[0]};
        end else if (code == ROM_2M) begin
            u = ram_bank;
        end else begin
            u = 2'b00;
        end
        return u;
    endfunction

endpackage

FILE: hw/rtl/cartridge_bank_controller.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller - MBC1 style cartridge memory bank controller
// Maps CPU bus words onto ROM addresses, bank registers and cartridge RAM.
// ----------------------------------------------------------------------------
// One bus word is taken per clock while o_in_stall is low and one result
// word comes out for each, in order. The accepting edge loads the issue
// stage and issues the access to the single-port cartridge RAM, whose read
// data is registered; a later edge loads the output register once it is
// free or drains. Writes to 0x0000-0x7FFF update the RAM enable, ROM bank,
// RAM bank and mode registers at the accept edge, so the very next word
// already sees them; a RAM write lands in the array at its accept edge and
// a following read sees it. The RAM holds undefined contents until written
// and needs no clearing after reset. The user must write the size codes
// only while the block is idle; the block itself does not enforce this.
// Results hold while o_out_valid is high and i_out_stall is high.
module cartridge_bank_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    // bus word in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    // result word out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_rom_fetch,
    output logic [20:0] o_rom_address,
    output logic [7:0]  o_read_data
);

    typedef struct packed {
        logic        rom_fetch;
        logic [20:0] rom_address;
        logic        use_mem;     // take read data from the RAM register
        logic [7:0]  const_data;  // read data when not from RAM
    } t_result;

    // Configuration and bank registers
    logic [2:0] r_rom_size;
    logic [2:0] r_ram_size;
    logic       r_ram_en;
    logic [4:0] r_rom_bank;
    logic [1:0] r_ram_bank;
    logic       r_mode;

    logic [7:0] cart_ram [cbc_pkg::CART_RAM_BYTES];
    logic [7:0] r_mem_q;

    // Pipeline: issue stage result and output register
    logic    r_s1_valid;
    t_result r_s1;
    logic    r_out_valid;
    t_result r_out;

    logic    s1_adv;
    logic    in_acc;

    // Decode of the incoming word
    logic [2:0]  code;
    logic [4:0]  mask;
    logic [1:0]  upper;
    logic        rom_region;
    logic        ram_region;
    logic        ram_ok;
    logic [14:0] ram_off;
    logic [4:0]  rd_bank;
    logic [6:0]  full_bank;
    logic        mem_wr;
    logic        mem_rd;
    t_result     n_s1;
    t_result     n_out;
    logic [4:0]  n_rom_bank;

    // Advance the issue stage whenever the output register is free or drains
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        code       = cbc_pkg::eff_rom_code(r_rom_size);
        mask       = cbc_pkg::bank_mask(code);
        upper      = cbc_pkg::upper_bits(code, r_ram_bank);
        rom_region = !i_address[15];
        ram_region = (i_address[15:13] == 3'b101);
        ram_ok     = r_ram_en && (r_ram_size == cbc_pkg::RAM_2K
                                  || r_ram_size == cbc_pkg::RAM_8K
                                  || r_ram_size == cbc_pkg::RAM_32K);

        // RAM offset: mirror small parts, bank the 32KB part in mode 1
        case (r_ram_size)
            cbc_pkg::RAM_2K: ram_off = {4'd0, i_address[10:0]};
            cbc_pkg::RAM_8K: ram_off = {2'd0, i_address[12:0]};
            default:         ram_off = r_mode ? {r_ram_bank, i_address[12:0]}
                                              : {2'd0, i_address[12:0]};
        endcase

        // Switchable bank: a zero bank reads as bank one
        rd_bank   = (r_rom_bank == 5'd0) ? 5'd1 : r_rom_bank;
        full_bank = {upper, rd_bank & mask};

        // New ROM bank value for a write to 0x2000-0x3FFF
        if (code == cbc_pkg::ROM_32K || i_write_data == 8'd0) begin
            n_rom_bank = 5'd1;
        end else begin
            n_rom_bank = i_write_data[4:0] & mask;
        end

        mem_wr = in_acc && i_opcode == cbc_pkg::OP_WRITE && ram_region && ram_ok;
        mem_rd = in_acc && i_opcode == cbc_pkg::OP_READ  && ram_region && ram_ok;

        n_s1 = '0;
        if (i_opcode == cbc_pkg::OP_READ) begin
            if (rom_region && !i_address[14]) begin
                n_s1.rom_fetch   = 1'b1;
                n_s1.rom_address = r_mode ? {upper, 5'd0, i_address[13:0]}
                                          : {5'd0, i_address};
            end else if (rom_region) begin
                n_s1.rom_fetch   = 1'b1;
                n_s1.rom_address = {full_bank, i_address[13:0]};
            end else if (ram_region && ram_ok) begin
                n_s1.use_mem     = 1'b1;
            end else begin
                n_s1.const_data  = cbc_pkg::OPEN_BUS;
            end
        end

        // Fold the RAM data in when moving to the output
        n_out            = r_s1;
        n_out.const_data = r_s1.use_mem ? r_mem_q : r_s1.const_data;
    end

    // Configuration and bank registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_size <= 3'd0;
            r_ram_size <= 3'd0;
            r_ram_en   <= 1'b0;
            r_rom_bank <= 5'd1;
            r_ram_bank <= 2'd0;
            r_mode     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == cbc_pkg::CFG_ROM_SIZE) begin
                    r_rom_size <= i_cfg_data;
                end else begin
                    r_ram_size <= i_cfg_data;
                end
            end
            if (in_acc && i_opcode == cbc_pkg::OP_WRITE && rom_region) begin
                case (i_address[14:13])
                    2'd0:    r_ram_en   <= (i_write_data[3:0] == cbc_pkg::RAM_EN_KEY);
                    2'd1:    r_rom_bank <= n_rom_bank;
                    2'd2:    r_ram_bank <= i_write_data[1:0];
                    default: r_mode     <= i_write_data[0];
                endcase
            end
        end
    end

    // Cartridge RAM: at most one access per accepted word, read data registered
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            cart_ram[ram_off[cbc_pkg::RAM_AW-1:0]] <= i_write_data;
        end
        if (mem_rd) begin
            r_mem_q <= cart_ram[ram_off[cbc_pkg::RAM_AW-1:0]];
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rom_fetch   = r_out.rom_fetch;
    assign o_rom_address = r_out.rom_address;
    assign o_read_data   = r_out.const_data;

    // Hold the RAM read register while its word waits in the issue stage
    a_mem_q_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> $stable(r_mem_q))
        else $error("RAM read data changed under a held word");

    // A held issue stage stays valid while the output is stalled
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |=> r_s1_valid)
        else $error("issue stage dropped a word under stall");

    // Non-ROM results carry a zero ROM address
    a_rom_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_rom_fetch) |-> (o_rom_address == 21'd0))
        else $error("ROM address set on a non-ROM result");

    // RAM reads and writes only for accepted words in the RAM window
    a_mem_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_wr || mem_rd) |-> (in_acc && ram_region && ram_ok))
        else $error("RAM accessed outside an accepted RAM word");

endmodule

FILE: tb/sv/cbc_tb_pkg.sv
// ----------------------------------------------------------------------------
// cbc_tb_pkg - bank mapping predictor and result scoreboard
// Keeps its own copy of the bank registers and cartridge RAM, works out the
// result word for every accepted bus word and checks results in order.
// ----------------------------------------------------------------------------
package cbc_tb_pkg;

    import cbc_pkg::*;

    // ROM and RAM size codes not named in the design package
    localparam logic [2:0] ROM_64K      = 3'd1;
    localparam logic [2:0] ROM_128K     = 3'd2;
    localparam logic [2:0] ROM_256K     = 3'd3;
    localparam logic [2:0] ROM_512K     = 3'd4;
    localparam logic [2:0] ROM_OVERSIZE = 3'd7;
    localparam logic [2:0] RAM_ABSENT   = 3'd0;
    localparam logic [2:0] RAM_BAD4     = 3'd4;
    localparam logic [2:0] RAM_BAD5     = 3'd5;
    localparam logic [2:0] RAM_BAD7     = 3'd7;

    typedef struct packed {
        logic        fetch;
        logic [20:0] rom_addr;
        logic [7:0]  data;
    } t_bus_result;

    class t_bank_scoreboard;

        logic [2:0]  rom_code;
        logic [2:0]  ram_code;
        logic        ram_on;
        logic [4:0]  rom_bank;
        logic [1:0]  ram_bank;
        logic        mode;
        logic [7:0]  cart_ram [CART_RAM_BYTES];
        bit          written [CART_RAM_BYTES];
        t_bus_result due_q [$];
        int unsigned errors;

        function new();
            rom_code = ROM_32K;
            ram_code = RAM_ABSENT;
            ram_on   = 1'b0;
            rom_bank = 5'd1;
            ram_bank = 2'd0;
            mode     = 1'b0;
            errors   = 0;
        endfunction

        function void set_size(input logic idx, input logic [2:0] val);
            if (idx == CFG_ROM_SIZE) begin
                rom_code = val;
            end else begin
                ram_code = val;
            end
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        // Oversized code behaves as the 2MB one
        function logic [2:0] rom_class();
            return (rom_code > ROM_2M) ? ROM_2M : rom_code;
        endfunction

        function logic [4:0] bank_bits(input logic [2:0] code);
            if (code >= ROM_512K) begin
                return 5'h1F;
            end
            return 5'((1 << (code + 1)) - 1);
        endfunction

        // Bank bits 6:5 borrowed from the RAM bank on the two largest ROMs
        function logic [1:0] high_bank(input logic [2:0] code);
            if (code == ROM_1M) begin
                return {1'b0, ram_bank[0]};
            end
            if (code == ROM_2M) begin
                return ram_bank;
            end
            return 2'b00;
        endfunction

        // Cartridge RAM offset of a 0xA000-0xBFFF address; 0 when RAM is shut
        function bit ram_slot(input logic [15:0] addr, output int unsigned off);
            int unsigned rel;
            rel = 32'(addr) - 32'hA000;
            off = 0;
            if (!ram_on) begin
                return 1'b0;
            end
            case (ram_code)
                RAM_2K: begin
                    off = rel % 2048;
                end
                RAM_8K: begin
                    off = rel % 8192;
                end
                RAM_32K: begin
                    off = mode ? (32'(ram_bank) * 32'h2000 + rel) : rel;
                end
                default: begin
                    return 1'b0;
                end
            endcase
            off = off % CART_RAM_BYTES;
            return 1'b1;
        endfunction

        function bit unsafe_read(input logic [15:0] addr);
            int unsigned off;
            if (addr < 16'hA000 || addr > 16'hBFFF) begin
                return 1'b0;
            end
            if (!ram_slot(addr, off)) begin
                return 1'b0;
            end
            return !written[off];
        endfunction

        // Apply one accepted bus word and queue the result it must give
        function void note_word(input logic op, input logic [15:0] addr,
                                input logic [7:0] data);
            t_bus_result r;
            logic [2:0]  code;
            logic [4:0]  bank5;
            int unsigned off;
            r    = '0;
            code = rom_class();
            if (op == OP_WRITE) begin
                if (addr <= 16'h1FFF) begin
                    ram_on = (data[3:0] == RAM_EN_KEY);
                end else if (addr <= 16'h3FFF) begin
                    if (code == ROM_32K || data == 8'h00) begin
                        rom_bank = 5'd1;
                    end else begin
                        rom_bank = data[4:0] & bank_bits(code);
                    end
                end else if (addr <= 16'h5FFF) begin
                    ram_bank = data[1:0];
                end else if (addr <= 16'h7FFF) begin
                    mode = data[0];
                end else if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
                    if (ram_slot(addr, off)) begin
                        cart_ram[off] = data;
                        written[off]  = 1'b1;
                    end
                end
            end else begin
                if (addr <= 16'h3FFF) begin
                    r.fetch    = 1'b1;
                    r.rom_addr = mode ? {high_bank(code), 5'b00000, addr[13:0]}
                                      : 21'(addr);
                end else if (addr <= 16'h7FFF) begin
                    bank5 = (rom_bank == 5'd0) ? 5'd1 : rom_bank;
                    r.fetch    = 1'b1;
                    r.rom_addr = {high_bank(code), bank5 & bank_bits(code), addr[13:0]};
                end else if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
                    r.data = ram_slot(addr, off) ? cart_ram[off] : OPEN_BUS;
                end else begin
                    r.data = OPEN_BUS;
                end
            end
            due_q.push_back(r);
        endfunction

        function void flag(input string what, input t_bus_result want,
                           input t_bus_result got);
            errors++;
            if (errors <= 10) begin
                $write("%s: expected fetch=%0b addr=%06h data=%02h, ",
                       what, want.fetch, want.rom_addr, want.data);
                $display("got fetch=%0b addr=%06h data=%02h",
                         got.fetch, got.rom_addr, got.data);
            end
        endfunction

        function void check_word(input logic fetch, input logic [20:0] rom_addr,
                                 input logic [7:0] data);
            t_bus_result got;
            t_bus_result want;
            got = {fetch, rom_addr, data};
            if (due_q.size() == 0) begin
                flag("result word with none outstanding", '0, got);
                return;
            end
            want = due_q.pop_front();
            if (got.fetch !== want.fetch || got.rom_addr !== want.rom_addr
                    || got.data !== want.data) begin
                flag("result word mismatch", want, got);
            end
        endfunction

    endclass

endpackage

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - cartridge bank controller testbench
// Drives CPU bus words through several ROM/RAM size settings, first a
// directed walk over the region edges and special cases, then random words
// built mostly from enable/bank/RAM sequences, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cbc_pkg::*;
    import cbc_tb_pkg::*;

    localparam int unsigned LIMIT     = 400000;
    localparam int          PHASES    = 9;
    localparam int          PER_PHASE = 105;

    // Directed walk: {opcode, address, data}. Opens with RAM shut, then
    // enables it, touches both RAM ends, zero and masked-to-zero ROM bank
    // writes, mode 1 with the upper bank bits, banked RAM, disabling again
    // and the unmapped regions.
    localparam logic [24:0] PROBE [27] = '{
        {OP_READ,  16'hA000, 8'h5C}, {OP_WRITE, 16'hA000, 8'h55},
        {OP_WRITE, 16'h0000, 8'h0A}, {OP_WRITE, 16'hA000, 8'h5A},
        {OP_READ,  16'hA000, 8'h00}, {OP_WRITE, 16'hBFFF, 8'hA5},
        {OP_READ,  16'hBFFF, 8'hFF}, {OP_WRITE, 16'h2000, 8'h00},
        {OP_READ,  16'h4000, 8'h00}, {OP_WRITE, 16'h3FFF, 8'hFF},
        {OP_READ,  16'h7FFF, 8'h00}, {OP_WRITE, 16'h2000, 8'h20},
        {OP_READ,  16'h4000, 8'h00}, {OP_WRITE, 16'h4000, 8'h03},
        {OP_WRITE, 16'h7FFF, 8'h01}, {OP_READ,  16'h0000, 8'h00},
        {OP_READ,  16'h3FFF, 8'h00}, {OP_WRITE, 16'hA000, 8'h3C},
        {OP_READ,  16'hA000, 8'h00}, {OP_WRITE, 16'h5FFF, 8'hFC},
        {OP_READ,  16'hA000, 8'h00}, {OP_WRITE, 16'h6000, 8'hFE},
        {OP_WRITE, 16'h1FFF, 8'hF0}, {OP_READ,  16'hBFFF, 8'h00},
        {OP_READ,  16'h8000, 8'h00}, {OP_WRITE, 16'h9FFF, 8'hFF},
        {OP_READ,  16'hFFFF, 8'h00}
    };

    // Size settings, one per phase; the oversized ROM code, the absent RAM code
    // and the unsupported RAM codes 4, 5 and 7 get a turn.
    localparam logic [2:0] ROM_PLAN [PHASES] = '{
        ROM_32K, ROM_2M, ROM_1M, ROM_OVERSIZE, ROM_64K,
        ROM_128K, ROM_256K, ROM_512K, ROM_2M
    };
    localparam logic [2:0] RAM_PLAN [PHASES] = '{
        RAM_ABSENT, RAM_32K, RAM_8K, RAM_2K, RAM_BAD4,
        RAM_32K, RAM_BAD5, RAM_BAD7, RAM_32K
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [2:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_opcode;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_rom_fetch;
    logic [20:0] o_rom_address;
    logic [7:0]  o_read_data;

    t_bank_scoreboard sb;
    bit               calm;         // suppress gaps and stalls while set
    int unsigned      cycles = 0;

    cartridge_bank_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_rom_fetch   (o_rom_fetch),
        .o_rom_address (o_rom_address),
        .o_read_data   (o_read_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: abandon the run once the cycle count reaches LIMIT
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Take a result word on every edge where it is valid and not held back
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            sb.check_word(o_rom_fetch, o_rom_address, o_read_data);
        end
    end

    // Result side back-pressure: free runs mixed with stall bursts, never two
    // bursts back to back; drop the stall altogether while calm is set.
    initial begin
        int unsigned left;
        logic        hold;
        left        = 0;
        hold        = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                if (!hold && $urandom_range(0, 2) == 0) begin
                    hold = 1'b1;
                    left = $urandom_range(1, 15);
                end else begin
                    hold = 1'b0;
                    left = $urandom_range(1, 20);
                end
            end
            i_out_stall = hold && !calm;
            left--;
        end
    end

    // Register writes happen only with the pipeline empty
    task automatic write_size(input logic idx, input logic [2:0] val);
        @(negedge i_clk);
        i_in_valid  = 1'b0;
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_size(idx, val);
    endtask

    // Drain: wait for every outstanding result, then let the pipe settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Offer one bus word, optionally after a gap, and hold it until taken
    task automatic send_word(input logic op, input logic [15:0] addr,
                             input logic [7:0] data);
        int unsigned gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        // A read of RAM never written has no defined answer: write it instead
        if (op == OP_READ && sb.unsafe_read(addr)) begin
            op = OP_WRITE;
        end
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_opcode     = op;
        i_address    = addr;
        i_write_data = data;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_word(op, addr, data);
    endtask

    // RAM window address, mostly near the bottom of each 2KB mirror so that
    // reads land on bytes already written
    function automatic logic [15:0] ram_address();
        int unsigned rel;
        if ($urandom_range(0, 9) < 7) begin
            rel = $urandom_range(0, 3) * 2048 + $urandom_range(0, 63);
        end else begin
            rel = $urandom_range(0, 16'h1FFF);
        end
        return 16'(32'hA000 + rel);
    endfunction

    // Random bus word: register writes, ROM reads, RAM traffic and the odd
    // unmapped access
    task automatic make_word(output logic op, output logic [15:0] addr,
                             output logic [7:0] data);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        data = 8'($urandom);
        op   = OP_WRITE;
        if (pick < 6) begin
            addr = 16'($urandom_range(16'h0000, 16'h1FFF));
            if ($urandom_range(0, 9) < 7) begin
                data[3:0] = RAM_EN_KEY;
            end
        end else if (pick < 12) begin
            addr = 16'($urandom_range(16'h2000, 16'h3FFF));
            if ($urandom_range(0, 9) == 0) begin
                data = 8'h00;
            end
        end else if (pick < 16) begin
            addr = 16'($urandom_range(16'h4000, 16'h5FFF));
        end else if (pick < 20) begin
            addr = 16'($urandom_range(16'h6000, 16'h7FFF));
        end else if (pick < 42) begin
            op   = OP_READ;
            addr = 16'($urandom_range(16'h0000, 16'h7FFF));
        end else if (pick < 90) begin
            op   = (pick < 65) ? OP_WRITE : OP_READ;
            addr = ram_address();
        end else begin
            op = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 0) begin
                addr = 16'($urandom_range(16'h8000, 16'h9FFF));
            end else begin
                addr = 16'($urandom_range(16'hC000, 16'hFFFF));
            end
        end
    endtask

    initial begin
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
        sb           = new();
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_ROM_SIZE;
        i_cfg_data   = 3'd0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_READ;
        i_address    = 16'h0000;
        i_write_data = 8'h00;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed walk on the largest ROM with banked RAM
        write_size(CFG_ROM_SIZE, ROM_2M);
        write_size(CFG_RAM_SIZE, RAM_32K);
        foreach (PROBE[k]) begin
            send_word(PROBE[k][24], PROBE[k][23:8], PROBE[k][7:0]);
        end

        // Random phases; one middle phase and the tail run without idling
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            write_size(CFG_ROM_SIZE, ROM_PLAN[ph]);
            write_size(CFG_RAM_SIZE, RAM_PLAN[ph]);
            for (int n = 0; n < PER_PHASE; n++) begin
                calm = (ph == 4) || (ph == PHASES - 1 && n >= 50);
                make_word(op, addr, data);
                send_word(op, addr, data);
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        calm       = 1'b1;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: cartridge_bank_controller.f
hw/rtl/cbc_pkg.sv
hw/rtl/cartridge_bank_controller.sv
tb/sv/cbc_tb_pkg.sv
tb/sv/tb_top.sv
